// File: hdl/wpel_pkg.sv
package wpel_pkg;

   // Buffer geometry
   localparam int RECORDS_PER_BUFFER = 16;
   localparam int NUM_POINTS         = 4;
   localparam int IDX_W  = (RECORDS_PER_BUFFER > 1) ? $clog2(RECORDS_PER_BUFFER) : 1;
   localparam int CNT_W  = $clog2(RECORDS_PER_BUFFER + 1);
   localparam int ADDR_W = IDX_W + 1;
   localparam int DEPTH  = 2 * (1 << IDX_W);

   // Field widths
   localparam int MASK_W  = 4;
   localparam int PT_IX_W = $clog2(MASK_W);
   localparam int POINT_W = 4;
   localparam int TS_W    = 32;
   localparam int VCAP_W  = 12;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   // Request word actions
   typedef enum logic [1:0] {
      ACT_EVENT = 2'd0,
      ACT_DRAIN = 2'd1,
      ACT_START = 2'd2,
      ACT_STOP  = 2'd3
   } action_type;

   // Response word kinds
   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   // Configuration register indexes
   localparam logic CSR_WATCH_MASK    = 1'b0;
   localparam logic CSR_SNAPSHOT_MASK = 1'b1;

   // One stored trace record, timestamp in the low bits
   typedef struct packed {
      logic [VCAP_W-1:0]  vcap;
      logic [POINT_W-1:0] point;
      logic [TS_W-1:0]    ts;
   } rec_type;

   // Controller to datapath
   typedef struct packed {
      logic ready;
      logic take;
      logic rd_issue;
      logic emit_rec;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic drain_nonempty;
      logic drain_last;
   } status_type;

endpackage

// File: hdl/watchpoint_event_pingpong_logger_core.sv
// Ping-pong trace logger. Codepoint events on points enabled in watch_mask append a
// record (timestamp, point, voltage sample when snapshot_mask enables it) to the current
// one of two 16-record buffers; a full buffer swaps over and raises ready_pending, or
// sets overflow_led when the other buffer is still waiting. Every request word gives one
// status word, except a drain, which gives one word per stored record (tlast on the final
// one) or a single empty-drain word. Event, start and stop words are accepted back to back
// as long as rsp_tready keeps the response register moving. A drain is walked by the
// controller, which reads each record from the record memory into a register in ST_READ
// and loads it into the response register in ST_EMIT, waiting there while the response
// register is busy; an empty drain loads its empty-drain word directly.
module watchpoint_event_pingpong_logger_core
   import wpel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // point_index[3:0], timestamp[35:4], vcap_sample[47:36]
   input  logic [1:0]            req_tuser,  // action[1:0]
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // rec_timestamp[31:0], rec_point[35:32],
                                             // rec_vcap[47:36], overflow_led[48],
                                             // ready_pending[49], zero[55:50]
   output logic [1:0]            rsp_tuser,  // kind[1:0]
   output logic                  rsp_tlast,
   // configuration writes
   input  logic                  csr_wen,
   input  logic                  csr_index,
   input  logic [MASK_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;
   action_type req_action;
   kind_type   rsp_kind;
   rec_type    rsp_rec;
   logic       rsp_ovf;
   logic       rsp_rdy;

   assign req_action = action_type'(req_tuser);

   wpel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   wpel_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_action (req_action),
      .req_point  (req_tdata[3:0]),
      .req_ts     (req_tdata[35:4]),
      .req_vcap   (req_tdata[47:36]),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .rsp_kind   (rsp_kind),
      .rsp_rec    (rsp_rec),
      .rsp_ovf    (rsp_ovf),
      .rsp_rdy    (rsp_rdy)
   );

   // Pack the response word
   assign req_tready = cmd.ready;
   assign rsp_tuser  = rsp_kind;
   assign rsp_tdata  = {6'b0, rsp_rdy, rsp_ovf, rsp_rec};

endmodule

// File: hdl/wpel_ctrl.sv
module wpel_ctrl
   import wpel_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  action_type req_action,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Accept a word only when idle and the response register can take a result
   always_comb begin
      cmd.ready    = (state_ff == ST_IDLE) && status.out_free;
      cmd.take     = cmd.ready && req_tvalid;
      cmd.rd_issue = (state_ff == ST_READ);
      cmd.emit_rec = (state_ff == ST_EMIT) && status.out_free;
   end

   // Walk the drained buffer: read a record, then hand it out
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take && (req_action == ACT_DRAIN) && status.drain_nonempty) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.emit_rec) begin
               state_in = status.drain_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/wpel_dpath.sv
module wpel_dpath
   import wpel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  action_type            req_action,
   input  logic [POINT_W-1:0]    req_point,
   input  logic [TS_W-1:0]       req_ts,
   input  logic [VCAP_W-1:0]     req_vcap,
   input  logic                  csr_wen,
   input  logic                  csr_index,
   input  logic [MASK_W-1:0]     csr_wdata,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic                  rsp_tlast,
   output kind_type              rsp_kind,
   output rec_type               rsp_rec,
   output logic                  rsp_ovf,
   output logic                  rsp_rdy
);

   // Control state
   logic [CNT_W-1:0]  fill_ff [2];
   logic [CNT_W-1:0]  fill_in [2];
   logic              cur_ff, cur_in;
   logic              ready_ff, ready_in;
   logic              ovf_ff, ovf_in;
   logic [MASK_W-1:0] watch_ff, watch_in;
   logic [MASK_W-1:0] snap_ff, snap_in;
   logic              out_valid_ff, out_valid_in;

   // Drain walk
   logic              drain_buf_ff, drain_buf_in;
   logic [IDX_W-1:0]  drain_idx_ff, drain_idx_in;
   logic [CNT_W-1:0]  drain_cnt_ff, drain_cnt_in;

   // Response payload
   kind_type          out_kind_ff, out_kind_in;
   rec_type           out_rec_ff, out_rec_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;
   logic              out_rdy_ff, out_rdy_in;

   // Record memory
   rec_type           mem [DEPTH];
   rec_type           rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   rec_type           mem_wdata;

   logic              pt_ok;
   logic [CNT_W-1:0]  fill_cur;
   logic [CNT_W-1:0]  fill_bump;
   logic              has_room;
   logic              other;
   logic              load_status;

   assign other    = ~cur_ff;
   assign fill_cur = fill_ff[cur_ff];
   assign has_room = fill_cur < CNT_W'(RECORDS_PER_BUFFER);
   assign fill_bump = has_room ? (fill_cur + CNT_W'(1)) : fill_cur;
   assign pt_ok    = ({1'b0, req_point} < (POINT_W + 1)'(NUM_POINTS)) &&
                     watch_ff[req_point[PT_IX_W-1:0]];

   assign status.out_free       = !out_valid_ff || rsp_tready;
   assign status.drain_nonempty = (fill_ff[other] != '0);
   assign status.drain_last     = (CNT_W'(drain_idx_ff) + CNT_W'(1)) == drain_cnt_ff;

   // Next-state logic for the buffers, flags and response register
   always_comb begin
      fill_in      = fill_ff;
      cur_in       = cur_ff;
      ready_in     = ready_ff;
      ovf_in       = ovf_ff;
      watch_in     = watch_ff;
      snap_in      = snap_ff;
      drain_buf_in = drain_buf_ff;
      drain_idx_in = drain_idx_ff;
      drain_cnt_in = drain_cnt_ff;
      out_kind_in  = out_kind_ff;
      out_rec_in   = out_rec_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      out_rdy_in   = out_rdy_ff;
      mem_we       = 1'b0;
      mem_waddr    = {cur_ff, fill_cur[IDX_W-1:0]};
      mem_wdata.ts    = req_ts;
      mem_wdata.point = req_point;
      mem_wdata.vcap  = snap_ff[req_point[PT_IX_W-1:0]] ? req_vcap : '0;
      load_status  = 1'b0;

      // Register writes
      if (csr_wen) begin
         unique case (csr_index)
            CSR_WATCH_MASK:    watch_in = csr_wdata;
            CSR_SNAPSHOT_MASK: snap_in  = csr_wdata;
            default:           watch_in = watch_ff;
         endcase
      end

      // Process an accepted request word
      if (cmd.take) begin
         unique case (req_action)
            ACT_EVENT: begin
               load_status = 1'b1;
               if (pt_ok) begin
                  mem_we          = has_room;
                  fill_in[cur_ff] = fill_bump;
                  if (fill_bump >= CNT_W'(RECORDS_PER_BUFFER)) begin
                     if (!ready_ff) begin
                        cur_in   = ~cur_ff;
                        ready_in = 1'b1;
                        ovf_in   = 1'b0;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end else begin
                     ovf_in = 1'b0;
                  end
               end
            end
            ACT_DRAIN: begin
               fill_in[other] = '0;
               ready_in       = 1'b0;
               drain_buf_in   = other;
               drain_idx_in   = '0;
               drain_cnt_in   = fill_ff[other];
               if (fill_ff[other] == '0) begin
                  load_status = 1'b1;
               end
            end
            ACT_START: begin
               load_status = 1'b1;
               fill_in[0]  = '0;
               fill_in[1]  = '0;
               cur_in      = 1'b0;
            end
            ACT_STOP: begin
               load_status = 1'b1;
               cur_in      = ~cur_ff;
               ready_in    = 1'b1;
            end
            default: begin
               load_status = 1'b0;
            end
         endcase
      end

      // Load a status or empty-drain word
      if (load_status) begin
         out_kind_in = (req_action == ACT_DRAIN) ? KIND_EMPTY : KIND_STATUS;
         out_rec_in  = '0;
         out_last_in = 1'b1;
         out_ovf_in  = ovf_in;
         out_rdy_in  = ready_in;
      end

      // Load a drained record and advance the walk
      if (cmd.emit_rec) begin
         out_kind_in  = KIND_RECORD;
         out_rec_in   = rd_data_ff;
         out_last_in  = status.drain_last;
         out_ovf_in   = ovf_ff;
         out_rdy_in   = ready_ff;
         drain_idx_in = drain_idx_ff + IDX_W'(1);
      end

      if (load_status || cmd.emit_rec) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff[0]   <= '0;
         fill_ff[1]   <= '0;
         cur_ff       <= 1'b0;
         ready_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         watch_ff     <= '0;
         snap_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         cur_ff       <= cur_in;
         ready_ff     <= ready_in;
         ovf_ff       <= ovf_in;
         watch_ff     <= watch_in;
         snap_ff      <= snap_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      drain_buf_ff <= drain_buf_in;
      drain_idx_ff <= drain_idx_in;
      drain_cnt_ff <= drain_cnt_in;
      out_kind_ff  <= out_kind_in;
      out_rec_ff   <= out_rec_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
      out_rdy_ff   <= out_rdy_in;
   end

   // Record memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[{drain_buf_ff, drain_idx_ff}];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_rec    = out_rec_ff;
   assign rsp_ovf    = out_ovf_ff;
   assign rsp_rdy    = out_rdy_ff;

`ifndef SYNTH
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_rec |-> status.out_free)
      else $error("record emitted while response register busy");

   a_drain_clears_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && (req_action == ACT_DRAIN)) |=> !ready_ff)
      else $error("ready flag still set after drain");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[0] <= CNT_W'(RECORDS_PER_BUFFER)) && (fill_ff[1] <= CNT_W'(RECORDS_PER_BUFFER)))
      else $error("fill count beyond buffer size");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_rec |-> (CNT_W'(drain_idx_ff) < drain_cnt_ff))
      else $error("drain index past drained count");
`endif

endmodule

// File: tb/wpel_trace_checker.sv
module wpel_trace_checker
   import wpel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic                  csr_index,
   input  logic [MASK_W-1:0]     csr_wdata,
   output int                    fail_count,
   output int                    pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   // Bit positions inside the request and response words
   localparam int REQ_TS_LO  = POINT_W;
   localparam int REQ_VC_LO  = POINT_W + TS_W;
   localparam int RSP_PT_LO  = TS_W;
   localparam int RSP_VC_LO  = TS_W + POINT_W;
   localparam int RSP_OVF    = TS_W + POINT_W + VCAP_W;
   localparam int RSP_RDY    = RSP_OVF + 1;

   typedef struct {
      kind_type           kind;
      logic [TS_W-1:0]    ts;
      logic [POINT_W-1:0] point;
      logic [VCAP_W-1:0]  vcap;
      logic               last;
      logic               overflow;
      logic               ready;
   } trace_word_type;

   trace_word_type    expected_words[$];

   // Shadow copy of the logger state
   logic [MASK_W-1:0] watch_mask;
   logic [MASK_W-1:0] snapshot_mask;
   rec_type           trace_store [2][RECORDS_PER_BUFFER];
   int unsigned       fill_count [2];
   logic              cur_buf;
   logic              ready_flag;
   logic              overflow_flag;
   int                mismatches;

   // Build one response word from the current flags
   function automatic trace_word_type make_word(kind_type kind, rec_type rec);
      trace_word_type w;
      w.kind     = kind;
      w.ts       = rec.ts;
      w.point    = rec.point;
      w.vcap     = rec.vcap;
      w.last     = 1'b0;
      w.overflow = overflow_flag;
      w.ready    = ready_flag;
      return w;
   endfunction

   // Append a record to the current buffer, swap or flag overflow when full
   task automatic log_event(logic [POINT_W-1:0] point, logic [TS_W-1:0] ts,
                            logic [VCAP_W-1:0] vcap);
      rec_type rec;
      if (point >= NUM_POINTS || !watch_mask[point[PT_IX_W-1:0]])
         return;
      if (fill_count[cur_buf] < RECORDS_PER_BUFFER) begin
         rec.ts    = ts;
         rec.point = point;
         rec.vcap  = snapshot_mask[point[PT_IX_W-1:0]] ? vcap : '0;
         trace_store[cur_buf][fill_count[cur_buf]] = rec;
         fill_count[cur_buf]++;
      end
      if (fill_count[cur_buf] >= RECORDS_PER_BUFFER) begin
         if (!ready_flag) begin
            cur_buf       = ~cur_buf;
            ready_flag    = 1'b1;
            overflow_flag = 1'b0;
         end else begin
            overflow_flag = 1'b1;
         end
      end else begin
         overflow_flag = 1'b0;
      end
   endtask

   // Advance the shadow state by one request word and queue its responses
   task automatic predict_trace_words(action_type act, logic [POINT_W-1:0] point,
                                      logic [TS_W-1:0] ts, logic [VCAP_W-1:0] vcap);
      trace_word_type words[$];
      trace_word_type w;
      rec_type        drained[$];
      logic           other;
      int unsigned    n;
      other = ~cur_buf;
      case (act)
         ACT_EVENT: begin
            log_event(point, ts, vcap);
            words.push_back(make_word(KIND_STATUS, '0));
         end
         ACT_DRAIN: begin
            n = fill_count[other];
            if (n > RECORDS_PER_BUFFER)
               n = RECORDS_PER_BUFFER;
            for (int i = 0; i < n; i++)
               drained.push_back(trace_store[other][i]);
            fill_count[other] = 0;
            ready_flag        = 1'b0;
            if (n == 0)
               words.push_back(make_word(KIND_EMPTY, '0));
            else
               foreach (drained[i])
                  words.push_back(make_word(KIND_RECORD, drained[i]));
         end
         ACT_START: begin
            fill_count[0] = 0;
            fill_count[1] = 0;
            cur_buf       = 1'b0;
            words.push_back(make_word(KIND_STATUS, '0));
         end
         default: begin
            cur_buf    = ~cur_buf;
            ready_flag = 1'b1;
            words.push_back(make_word(KIND_STATUS, '0));
         end
      endcase
      foreach (words[i]) begin
         w      = words[i];
         w.last = (i == words.size() - 1);
         expected_words.push_back(w);
      end
   endtask

   // Watch all three ports on each rising edge
   always @(posedge clock) begin
      trace_word_type want;
      if (reset) begin
         watch_mask    = '0;
         snapshot_mask = '0;
         fill_count[0] = 0;
         fill_count[1] = 0;
         cur_buf       = 1'b0;
         ready_flag    = 1'b0;
         overflow_flag = 1'b0;
         expected_words.delete();
      end else begin
         // Compare a response word with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp word: kind %0d ts %h pt %0d vcap %h last %b",
                           rsp_tuser, rsp_tdata[TS_W-1:0], rsp_tdata[RSP_PT_LO +: POINT_W],
                           rsp_tdata[RSP_VC_LO +: VCAP_W], rsp_tlast);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tuser != want.kind || rsp_tdata[TS_W-1:0] != want.ts ||
                   rsp_tdata[RSP_PT_LO +: POINT_W] != want.point ||
                   rsp_tdata[RSP_VC_LO +: VCAP_W] != want.vcap || rsp_tlast != want.last ||
                   rsp_tdata[RSP_OVF] != want.overflow || rsp_tdata[RSP_RDY] != want.ready)
               begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("rsp mismatch: expected kind %0d ts %h pt %0d vcap %h last %b ovf %b rdy %b",
                              want.kind, want.ts, want.point, want.vcap, want.last,
                              want.overflow, want.ready);
                     $display("              got      kind %0d ts %h pt %0d vcap %h last %b ovf %b rdy %b",
                              rsp_tuser, rsp_tdata[TS_W-1:0], rsp_tdata[RSP_PT_LO +: POINT_W],
                              rsp_tdata[RSP_VC_LO +: VCAP_W], rsp_tlast,
                              rsp_tdata[RSP_OVF], rsp_tdata[RSP_RDY]);
                  end
               end
            end
         end
         // Track register writes
         if (csr_wen) begin
            if (csr_index == CSR_WATCH_MASK)
               watch_mask = csr_wdata;
            else
               snapshot_mask = csr_wdata;
         end
         // Predict the responses of an accepted request word
         if (req_tvalid && req_tready)
            predict_trace_words(action_type'(req_tuser), req_tdata[POINT_W-1:0],
                                req_tdata[REQ_TS_LO +: TS_W], req_tdata[REQ_VC_LO +: VCAP_W]);
      end
      fail_count    <= mismatches;
      pending_words <= expected_words.size();
   end

endmodule

// File: tb/watchpoint_event_pingpong_logger_core_test.sv
module watchpoint_event_pingpong_logger_core_test
   import wpel_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wen    = 1'b0;
   logic                  csr_index  = 1'b0;
   logic [MASK_W-1:0]     csr_wdata  = '0;

   int fail_count;
   int pending_words;
   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int hold_left       = 0;

   always #4 clock = ~clock;

   watchpoint_event_pingpong_logger_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wpel_trace_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   // Receiver: hold off for a counted stretch on request, else stall at random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one request word after a random gap, return once it is taken
   task automatic send_word(action_type act, logic [POINT_W-1:0] point,
                            logic [TS_W-1:0] ts, logic [VCAP_W-1:0] vcap);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {vcap, ts, point};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   task automatic write_masks(logic [MASK_W-1:0] watch, logic [MASK_W-1:0] snap);
      csr_wen   <= 1'b1;
      csr_index <= CSR_WATCH_MASK;
      csr_wdata <= watch;
      @(posedge clock);
      csr_index <= CSR_SNAPSHOT_MASK;
      csr_wdata <= snap;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Mostly events on live points, with drains, starts and stops mixed in
   task automatic send_random_word();
      int                 r;
      action_type         act;
      logic [POINT_W-1:0] point;
      r     = $urandom_range(99);
      act   = (r < 70) ? ACT_EVENT : (r < 84) ? ACT_DRAIN : (r < 90) ? ACT_START : ACT_STOP;
      point = ($urandom_range(9) < 8) ? POINT_W'($urandom_range(NUM_POINTS - 1)) :
                                        POINT_W'($urandom_range(15));
      send_word(act, point, $urandom, VCAP_W'($urandom_range(4095)));
   endtask

   // One idling setting with its own masks; bursts can fill buffers to the top
   task automatic run_phase(int idle, int stall, logic [MASK_W-1:0] watch,
                            logic [MASK_W-1:0] snap, int count);
      int sent;
      int n;
      wait_idle();
      write_masks(watch, snap);
      sender_idle_pct = idle;
      stall_pct       = stall;
      sent            = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            n = $urandom_range(34, 16);
            repeat (n)
               send_word(ACT_EVENT, POINT_W'($urandom_range(NUM_POINTS - 1)), $urandom,
                         VCAP_W'($urandom_range(4095)));
            sent += n;
         end else begin
            send_random_word();
            sent++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: masks cleared, drain with nothing ready
      write_masks(4'h0, 4'h0);
      send_word(ACT_EVENT, 4'd0, 32'h0000_0001, 12'hfff);
      send_word(ACT_DRAIN, 4'd0, '0, '0);

      // Directed: field extremes, snapshot on points 0 and 2 only, ignored points
      wait_idle();
      write_masks(4'hf, 4'h5);
      send_word(ACT_EVENT, 4'd0, 32'h0000_0000, 12'h000);
      send_word(ACT_EVENT, 4'd1, 32'hffff_ffff, 12'hfff);
      send_word(ACT_EVENT, 4'd2, 32'h1234_5678, 12'hfff);
      send_word(ACT_EVENT, 4'd3, 32'h8000_0000, 12'h800);
      send_word(ACT_EVENT, 4'd4, 32'hdead_beef, 12'h555);
      send_word(ACT_EVENT, 4'd15, 32'hffff_ffff, 12'hfff);

      // Directed: stop then drain, drain with ready clear, double stop
      send_word(ACT_STOP, 4'd0, '0, '0);
      send_word(ACT_DRAIN, 4'd0, '0, '0);
      send_word(ACT_DRAIN, 4'd0, '0, '0);
      send_word(ACT_EVENT, 4'd3, 32'h5a5a_a5a5, 12'h7ff);
      send_word(ACT_STOP, 4'd0, '0, '0);
      send_word(ACT_STOP, 4'd0, '0, '0);
      send_word(ACT_DRAIN, 4'd0, '0, '0);
      send_word(ACT_START, 4'd0, '0, '0);
      send_word(ACT_EVENT, 4'd2, 32'h0f0f_0f0f, 12'h0aa);
      send_word(ACT_DRAIN, 4'd0, '0, '0);
      send_word(ACT_START, 4'd0, '0, '0);

      // Back-pressure: receiver holds off, stalling the event words, which then fill both buffers and overflow
      wait_idle();
      write_masks(4'hf, 4'hf);
      hold_left = 300;
      repeat (40)
         send_word(ACT_EVENT, POINT_W'($urandom_range(NUM_POINTS - 1)), $urandom,
                   VCAP_W'($urandom_range(4095)));
      send_word(ACT_DRAIN, 4'd0, '0, '0);

      // Random phases over the idling settings
      run_phase(0, 0, 4'hf, 4'hf, 70);
      run_phase(79, 0, MASK_W'($urandom_range(15, 1)), MASK_W'($urandom_range(15)), 70);
      run_phase(0, 79, 4'hf, 4'h0, 70);
      run_phase(15, 15, MASK_W'($urandom_range(15, 1)), MASK_W'($urandom_range(15)), 70);

      // Let the last words drain and give stray words a chance to show
      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #8000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
